@@ sv/bezier_polyline_sampler_top_defines.svh @@
// assertion macros for the bezier polyline sampler
// used by bezier_polyline_sampler_top, expects clk and rst_n in scope
`ifndef BEZIER_POLYLINE_SAMPLER_TOP_DEFINES_SVH
`define BEZIER_POLYLINE_SAMPLER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bps_pkg.sv @@
// shared types, codes and constants for the bezier polyline sampler
// no dependencies
package bps_pkg;

    localparam int SAMPLE_STEPS_DEF = 1023;
    localparam int MAX_CTRL_DEF     = 16;

    localparam int COORD_W = 16;
    localparam int POS_W   = 10;
    localparam int DIST_W  = 32;
    localparam int CFG_W   = 16;
    localparam int ROOT_W  = 32;
    localparam int RAD_W   = 2 * ROOT_W;

    localparam logic [63:0] HALF_Q30 = 64'd1 << 29;
    localparam logic [31:0] ONE_Q30  = 32'd1 << 30;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_NEAREST = 2'd1,
        OP_AT_POS  = 2'd2,
        OP_EXTENTS = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_BUILT = 2'd2;

    localparam logic [1:0] CFG_DEDUP  = 2'd0;
    localparam logic [1:0] CFG_XSCALE = 2'd1;
    localparam logic [1:0] CFG_YSCALE = 2'd2;

    localparam logic [1:0] DEDUP_BOTH = 2'd0;
    localparam logic [1:0] DEDUP_X    = 2'd1;
    localparam logic [1:0] DEDUP_Y    = 2'd2;

    // round half up of a q30 sum, saturated to 16 bits signed
    function automatic logic signed [COORD_W-1:0] round_q30_sat(logic signed [63:0] v);
        logic signed [63:0] r;
        logic signed [63:0] q;
        r = v + $signed(HALF_Q30);
        q = r >>> 30;
        if (q > 64'sd32767)
            return 16'sh7fff;
        else if (q < -64'sd32768)
            return 16'sh8000;
        else
            return q[COORD_W-1:0];
    endfunction

endpackage

@@ sv/bps_isqrt.sv @@
// digit-by-digit integer square root, two radicand bits per cycle
// depends on bps_pkg
module bps_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bps_pkg::RAD_W-1:0]  radicand,
    output logic                       done,
    output logic [bps_pkg::ROOT_W-1:0] root
);
    import bps_pkg::*;

    localparam int CW = $clog2(ROOT_W);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [RAD_W-1:0]  val_reg, val_next;
    logic [ROOT_W+1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [ROOT_W+3:0] rem_sh;
    logic [ROOT_W+3:0] trial;
    logic              ge;

    assign rem_sh = {rem_reg, val_reg[RAD_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            run_next  = 1'b1;
            cnt_next  = '0;
            val_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (run_reg)
        begin
            rem_next  = ge ? (ROOT_W+2)'(rem_sh - trial) : (ROOT_W+2)'(rem_sh);
            root_next = {root_reg[ROOT_W-2:0], ge};
            val_next  = {val_reg[RAD_W-3:0], 2'b00};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CW'(ROOT_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ sv/bezier_polyline_sampler_top.sv @@
// bezier polyline sampler: control point store, curve builder, sample store and queries
// depends on bps_pkg, bps_isqrt and bezier_polyline_sampler_top_defines.svh
`include "bezier_polyline_sampler_top_defines.svh"
//
// Usage: drive operation, coord_x, coord_y, position and last_point with start
// high; the word is taken at a clock edge where busy is low. One result word
// follows, flagged by done for a single cycle; the receiver cannot stall it.
// Config writes (cfg_write, cfg_index, cfg_data) are to go in while the block is idle; the block does not enforce it.
// A load without build gives its result on the cycle after the accept. A load
// with build evaluates every sample on the single shared 33x33 multiplier, which
// does every Bernstein product. A nearest query scans the samples on the
// multiplier, then runs the 32-step root unit. A position or extents query reads
// each stored sample once. A query before any build gives its result on the next
// cycle with status not built.
// Items are processed one at a time; busy stays high until the result goes out.
// Reset clears the control count, the sample count and the built flag; the
// stores themselves are not cleared.
module bezier_polyline_sampler_top #(
    parameter int SAMPLE_STEPS       = bps_pkg::SAMPLE_STEPS_DEF,
    parameter int MAX_CONTROL_POINTS = bps_pkg::MAX_CTRL_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         operation,
    input  logic signed [bps_pkg::COORD_W-1:0] coord_x,
    input  logic signed [bps_pkg::COORD_W-1:0] coord_y,
    input  logic [bps_pkg::POS_W-1:0]          position,
    input  logic                               last_point,
    input  logic                               cfg_write,
    input  logic [1:0]                         cfg_index,
    input  logic [bps_pkg::CFG_W-1:0]          cfg_data,
    output logic                               done,
    output logic [1:0]                         status,
    output logic [bps_pkg::POS_W-1:0]          sample_position,
    output logic signed [bps_pkg::COORD_W-1:0] point_x,
    output logic signed [bps_pkg::COORD_W-1:0] point_y,
    output logic [bps_pkg::DIST_W-1:0]         distance,
    output logic [bps_pkg::COORD_W-1:0]        extent_width,
    output logic [bps_pkg::COORD_W-1:0]        extent_height
);
    import bps_pkg::*;

    localparam int DEPTH = SAMPLE_STEPS + 1;
    localparam int JW    = $clog2(DEPTH);
    localparam int CNW   = $clog2(DEPTH + 1);
    localparam int KW    = $clog2(MAX_CONTROL_POINTS + 1);
    localparam int CIW   = (MAX_CONTROL_POINTS > 1) ? $clog2(MAX_CONTROL_POINTS) : 1;
    localparam int RW    = $clog2(2 * SAMPLE_STEPS);
    localparam int BD_W  = 33;
    localparam logic [30:0]   T_STEP = 31'((64'd1 << 30) / SAMPLE_STEPS);
    localparam logic [RW-1:0] R_STEP = RW'((64'd1 << 30) % SAMPLE_STEPS);
    localparam logic [RW-1:0] R_INIT = RW'(SAMPLE_STEPS / 2);
    localparam logic [RW-1:0] N_R    = RW'(SAMPLE_STEPS);
    localparam logic [JW-1:0] N_J    = JW'(SAMPLE_STEPS);

    typedef struct packed {
        logic [JW-1:0]             pos;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } sample_t;

    typedef enum logic [4:0] {
        S_IDLE, S_B_INIT, S_B_UB, S_B_TB, S_B_WR, S_B_SX, S_B_SY, S_B_SA,
        S_B_KEEP, S_B_FIN, S_Q_RD, S_Q_DAT, S_Q_M2, S_Q_CMP, S_Q_END,
        S_D_B, S_D_C, S_D_D, S_D_E, S_D_SQ
    } state_t;

    // registers
    state_t                     state_reg, state_next;
    logic [1:0]                 dedup_reg, dedup_next;
    logic [CFG_W-1:0]           xscale_reg, xscale_next;
    logic [CFG_W-1:0]           yscale_reg, yscale_next;
    logic [KW-1:0]              ctrl_cnt_reg, ctrl_cnt_next;
    logic                       ready_reg, ready_next;
    logic [CNW-1:0]             smp_cnt_reg, smp_cnt_next;
    op_t                        op_reg, op_next;
    logic                       full_reg, full_next;
    logic signed [COORD_W-1:0]  qx_reg, qx_next;
    logic signed [COORD_W-1:0]  qy_reg, qy_next;
    logic [POS_W-1:0]           qpos_reg, qpos_next;
    logic [JW-1:0]              j_reg, j_next;
    logic [30:0]                t_reg, t_next;
    logic [RW-1:0]              tr_reg, tr_next;
    logic [KW-1:0]              m_reg, m_next;
    logic [KW-1:0]              k_reg, k_next;
    logic [KW-1:0]              nn_reg, nn_next;
    logic [63:0]                acc_reg, acc_next;
    logic signed [63:0]         sx_reg, sx_next;
    logic signed [63:0]         sy_reg, sy_next;
    logic signed [COORD_W-1:0]  ox_reg, ox_next;
    logic signed [COORD_W-1:0]  oy_reg, oy_next;
    logic [CNW-1:0]             i_reg, i_next;
    logic [BD_W-1:0]            bd_reg, bd_next;
    logic signed [COORD_W-1:0]  bx_reg, bx_next;
    logic signed [COORD_W-1:0]  by_reg, by_next;
    logic [JW-1:0]              bp_reg, bp_next;
    logic signed [COORD_W:0]    w_reg, w_next;
    logic signed [COORD_W:0]    h_reg, h_next;
    logic [31:0]                sa_reg, sa_next;
    logic [31:0]                sb_reg, sb_next;
    logic [63:0]                a2_reg, a2_next;
    logic [31:0]                p1_reg, p1_next;
    logic                       done_reg, done_next;
    logic [1:0]                 status_reg, status_next;
    logic [POS_W-1:0]           spos_reg, spos_next;
    logic signed [COORD_W-1:0]  px_reg, px_next;
    logic signed [COORD_W-1:0]  py_reg, py_next;
    logic [DIST_W-1:0]          dist_reg, dist_next;
    logic [COORD_W-1:0]         ew_reg, ew_next;
    logic [COORD_W-1:0]         eh_reg, eh_next;
    logic signed [65:0]         prod_reg, prod_next;

    // storage
    logic signed [COORD_W-1:0]  ctrl_x_mem [MAX_CONTROL_POINTS];
    logic signed [COORD_W-1:0]  ctrl_y_mem [MAX_CONTROL_POINTS];
    logic [31:0]                bern_reg   [MAX_CONTROL_POINTS];
    sample_t                    smp_mem    [DEPTH];
    sample_t                    rd_reg;

    // combinational helpers
    logic signed [32:0]         mul_a, mul_b;
    logic                       ctrl_we;
    logic [CIW-1:0]             ctrl_widx;
    logic                       bern_clr, bern_we;
    logic [31:0]                bern_wdata;
    logic [CIW-1:0]             k_idx, bern_ridx;
    logic [31:0]                bern_rd;
    logic                       mem_we;
    logic [JW-1:0]              mem_waddr;
    sample_t                    mem_wdata;
    logic [KW-1:0]              cnt_after;
    logic [30:0]                u_val;
    logic [RW-1:0]              tr_sum;
    logic [63:0]                bsum;
    logic signed [COORD_W-1:0]  cx, cy;
    logic                       keep;
    logic signed [COORD_W:0]    dx, dy, dbx, dby;
    logic [COORD_W-1:0]         dbx_mag, dby_mag;
    logic signed [12:0]         pdiff;
    logic [12:0]                pmag;
    logic [BD_W-1:0]            dsq;
    logic [64:0]                ssum;
    logic                       last_smp;
    logic                       sq_start, sq_done;
    logic [ROOT_W-1:0]          sq_root;

    assign u_val     = 31'(ONE_Q30) - t_reg;
    assign k_idx     = k_reg[CIW-1:0];
    assign bern_ridx = (state_reg == S_B_TB) ? CIW'(k_reg - 1'b1) : k_idx;
    assign bern_rd   = bern_reg[bern_ridx];
    assign tr_sum    = tr_reg + R_STEP;
    assign bsum      = acc_reg + prod_reg[63:0] + HALF_Q30;
    assign cx        = round_q30_sat(sx_reg);
    assign cy        = round_q30_sat(sy_reg);
    assign dx        = (COORD_W+1)'(rd_reg.x) - (COORD_W+1)'(qx_reg);
    assign dy        = (COORD_W+1)'(rd_reg.y) - (COORD_W+1)'(qy_reg);
    assign dbx       = (COORD_W+1)'(bx_reg) - (COORD_W+1)'(qx_reg);
    assign dby       = (COORD_W+1)'(by_reg) - (COORD_W+1)'(qy_reg);
    assign dbx_mag   = dbx[COORD_W] ? COORD_W'(-dbx) : COORD_W'(dbx);
    assign dby_mag   = dby[COORD_W] ? COORD_W'(-dby) : COORD_W'(dby);
    assign pdiff     = $signed({1'b0, 12'(rd_reg.pos)}) - $signed({3'b000, qpos_reg});
    assign pmag      = pdiff[12] ? 13'(-pdiff) : 13'(pdiff);
    assign dsq       = BD_W'(p1_reg) + BD_W'(prod_reg[31:0]);
    assign ssum      = {1'b0, a2_reg} + {1'b0, prod_reg[63:0]};
    assign last_smp  = (i_reg + 1'b1) == smp_cnt_reg;
    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        case (dedup_reg)
            DEDUP_BOTH: keep = (cx != ox_reg) || (cy != oy_reg);
            DEDUP_X:    keep = cx != ox_reg;
            DEDUP_Y:    keep = cy != oy_reg;
            default:    keep = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        dedup_next    = dedup_reg;
        xscale_next   = xscale_reg;
        yscale_next   = yscale_reg;
        ctrl_cnt_next = ctrl_cnt_reg;
        ready_next    = ready_reg;
        smp_cnt_next  = smp_cnt_reg;
        op_next       = op_reg;
        full_next     = full_reg;
        qx_next       = qx_reg;
        qy_next       = qy_reg;
        qpos_next     = qpos_reg;
        j_next        = j_reg;
        t_next        = t_reg;
        tr_next       = tr_reg;
        m_next        = m_reg;
        k_next        = k_reg;
        nn_next       = nn_reg;
        acc_next      = acc_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        i_next        = i_reg;
        bd_next       = bd_reg;
        bx_next       = bx_reg;
        by_next       = by_reg;
        bp_next       = bp_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        sa_next       = sa_reg;
        sb_next       = sb_reg;
        a2_next       = a2_reg;
        p1_next       = p1_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        spos_next     = spos_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        dist_next     = dist_reg;
        ew_next       = ew_reg;
        eh_next       = eh_reg;
        mul_a         = '0;
        mul_b         = '0;
        ctrl_we       = 1'b0;
        ctrl_widx     = ctrl_cnt_reg[CIW-1:0];
        bern_clr      = 1'b0;
        bern_we       = 1'b0;
        bern_wdata    = bsum[61:30];
        mem_we        = 1'b0;
        mem_waddr     = smp_cnt_reg[JW-1:0];
        mem_wdata     = '{pos: j_reg, x: cx, y: cy};
        cnt_after     = ctrl_cnt_reg;
        sq_start      = 1'b0;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_DEDUP:  dedup_next  = cfg_data[1:0];
                CFG_XSCALE: xscale_next = cfg_data;
                CFG_YSCALE: yscale_next = cfg_data;
                default:    ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (operation == OP_LOAD)
                    begin
                        if (ctrl_cnt_reg < KW'(MAX_CONTROL_POINTS))
                        begin
                            ctrl_we   = 1'b1;
                            cnt_after = ctrl_cnt_reg + 1'b1;
                            full_next = 1'b0;
                        end
                        else
                        begin
                            full_next = 1'b1;
                        end
                        ctrl_cnt_next = cnt_after;
                        if (last_point && (cnt_after != '0))
                        begin
                            nn_next      = cnt_after - 1'b1;
                            j_next       = '0;
                            t_next       = '0;
                            tr_next      = R_INIT;
                            smp_cnt_next = '0;
                            state_next   = S_B_INIT;
                        end
                        else
                        begin
                            done_next   = 1'b1;
                            status_next = (cnt_after == ctrl_cnt_reg) ? ST_FULL : ST_OK;
                            spos_next   = '0;
                            px_next     = '0;
                            py_next     = '0;
                            dist_next   = '0;
                            ew_next     = '0;
                            eh_next     = '0;
                        end
                    end
                    else if (!ready_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_NOT_BUILT;
                        spos_next   = '0;
                        px_next     = '0;
                        py_next     = '0;
                        dist_next   = '0;
                        ew_next     = '0;
                        eh_next     = '0;
                    end
                    else
                    begin
                        op_next    = op_t'(operation);
                        qx_next    = coord_x;
                        qy_next    = coord_y;
                        qpos_next  = position;
                        i_next     = '0;
                        w_next     = '0;
                        h_next     = '0;
                        state_next = S_Q_RD;
                    end
                end
            end

            // one sample: weight recurrence, weighted sums, then keep test
            S_B_INIT:
            begin
                bern_clr = 1'b1;
                sx_next  = '0;
                sy_next  = '0;
                if (nn_reg == '0)
                begin
                    k_next     = '0;
                    state_next = S_B_SX;
                end
                else
                begin
                    m_next     = KW'(1);
                    k_next     = KW'(1);
                    state_next = S_B_UB;
                end
            end

            S_B_UB:
            begin
                if (k_reg != m_reg)
                begin
                    mul_a = {2'b00, u_val};
                    mul_b = {1'b0, bern_rd};
                end
                state_next = S_B_TB;
            end

            S_B_TB:
            begin
                acc_next = prod_reg[63:0];
                if (k_reg != '0)
                begin
                    mul_a = {2'b00, t_reg};
                    mul_b = {1'b0, bern_rd};
                end
                state_next = S_B_WR;
            end

            S_B_WR:
            begin
                bern_we = 1'b1;
                if (k_reg == '0)
                begin
                    if (m_reg == nn_reg)
                    begin
                        state_next = S_B_SX;
                    end
                    else
                    begin
                        m_next     = m_reg + 1'b1;
                        k_next     = m_reg + 1'b1;
                        state_next = S_B_UB;
                    end
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = S_B_UB;
                end
            end

            S_B_SX:
            begin
                mul_a      = {1'b0, bern_rd};
                mul_b      = 33'(ctrl_x_mem[k_idx]);
                state_next = S_B_SY;
            end

            S_B_SY:
            begin
                sx_next    = sx_reg + $signed(prod_reg[63:0]);
                mul_a      = {1'b0, bern_rd};
                mul_b      = 33'(ctrl_y_mem[k_idx]);
                state_next = S_B_SA;
            end

            S_B_SA:
            begin
                sy_next = sy_reg + $signed(prod_reg[63:0]);
                if (k_reg == nn_reg)
                begin
                    state_next = S_B_KEEP;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_B_SX;
                end
            end

            S_B_KEEP:
            begin
                if ((j_reg == '0) || keep)
                begin
                    mem_we       = 1'b1;
                    smp_cnt_next = smp_cnt_reg + 1'b1;
                    ox_next      = cx;
                    oy_next      = cy;
                end
                if (j_reg == N_J)
                begin
                    state_next = S_B_FIN;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    // t = round(j * 2^30 / N) kept as quotient and remainder
                    if (tr_sum >= N_R)
                    begin
                        tr_next = tr_sum - N_R;
                        t_next  = t_reg + T_STEP + 31'd1;
                    end
                    else
                    begin
                        tr_next = tr_sum;
                        t_next  = t_reg + T_STEP;
                    end
                    state_next = S_B_INIT;
                end
            end

            S_B_FIN:
            begin
                // last kept sample gets the end position, a lone sample is doubled
                mem_we    = 1'b1;
                mem_wdata = '{pos: N_J, x: ox_reg, y: oy_reg};
                if (smp_cnt_reg == CNW'(1))
                begin
                    mem_waddr    = JW'(1);
                    smp_cnt_next = CNW'(2);
                end
                else
                begin
                    mem_waddr = JW'(smp_cnt_reg - 1'b1);
                end
                ready_next    = 1'b1;
                ctrl_cnt_next = '0;
                done_next     = 1'b1;
                status_next   = full_reg ? ST_FULL : ST_OK;
                spos_next     = '0;
                px_next       = '0;
                py_next       = '0;
                dist_next     = '0;
                ew_next       = '0;
                eh_next       = '0;
                state_next    = S_IDLE;
            end

            S_Q_RD:
            begin
                state_next = S_Q_DAT;
            end

            S_Q_DAT:
            begin
                case (op_reg)
                    OP_NEAREST:
                    begin
                        mul_a      = 33'(dx);
                        mul_b      = 33'(dx);
                        state_next = S_Q_M2;
                    end
                    OP_AT_POS:
                    begin
                        if ((i_reg == '0) || (BD_W'(pmag) <= bd_reg))
                        begin
                            bd_next = BD_W'(pmag);
                            bx_next = rd_reg.x;
                            by_next = rd_reg.y;
                            bp_next = rd_reg.pos;
                        end
                        i_next     = i_reg + 1'b1;
                        state_next = last_smp ? S_Q_END : S_Q_RD;
                    end
                    default:
                    begin
                        if ((COORD_W+1)'(rd_reg.x) >= w_reg)
                            w_next = (COORD_W+1)'(rd_reg.x) + 1'b1;
                        if ((COORD_W+1)'(rd_reg.y) >= h_reg)
                            h_next = (COORD_W+1)'(rd_reg.y) + 1'b1;
                        i_next     = i_reg + 1'b1;
                        state_next = last_smp ? S_Q_END : S_Q_RD;
                    end
                endcase
            end

            S_Q_M2:
            begin
                p1_next    = prod_reg[31:0];
                mul_a      = 33'(dy);
                mul_b      = 33'(dy);
                state_next = S_Q_CMP;
            end

            S_Q_CMP:
            begin
                // strict compare keeps the first sample on ties
                if ((i_reg == '0) || (dsq < bd_reg))
                begin
                    bd_next = dsq;
                    bx_next = rd_reg.x;
                    by_next = rd_reg.y;
                    bp_next = rd_reg.pos;
                end
                i_next     = i_reg + 1'b1;
                state_next = last_smp ? S_Q_END : S_Q_RD;
            end

            S_Q_END:
            begin
                if (op_reg == OP_NEAREST)
                begin
                    mul_a      = {17'd0, xscale_reg};
                    mul_b      = {17'd0, dbx_mag};
                    state_next = S_D_B;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    dist_next   = '0;
                    if (op_reg == OP_AT_POS)
                    begin
                        spos_next = POS_W'(bp_reg);
                        px_next   = bx_reg;
                        py_next   = by_reg;
                        ew_next   = '0;
                        eh_next   = '0;
                    end
                    else
                    begin
                        spos_next = '0;
                        px_next   = '0;
                        py_next   = '0;
                        ew_next   = w_reg[COORD_W-1:0];
                        eh_next   = h_reg[COORD_W-1:0];
                    end
                    state_next = S_IDLE;
                end
            end

            S_D_B:
            begin
                sa_next    = prod_reg[31:0];
                mul_a      = {17'd0, yscale_reg};
                mul_b      = {17'd0, dby_mag};
                state_next = S_D_C;
            end

            S_D_C:
            begin
                sb_next    = prod_reg[31:0];
                mul_a      = {1'b0, sa_reg};
                mul_b      = {1'b0, sa_reg};
                state_next = S_D_D;
            end

            S_D_D:
            begin
                a2_next    = prod_reg[63:0];
                mul_a      = {1'b0, sb_reg};
                mul_b      = {1'b0, sb_reg};
                state_next = S_D_E;
            end

            S_D_E:
            begin
                if (ssum[64])
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    spos_next   = POS_W'(bp_reg);
                    px_next     = bx_reg;
                    py_next     = by_reg;
                    dist_next   = '1;
                    ew_next     = '0;
                    eh_next     = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    sq_start   = 1'b1;
                    state_next = S_D_SQ;
                end
            end

            S_D_SQ:
            begin
                if (sq_done)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    spos_next   = POS_W'(bp_reg);
                    px_next     = bx_reg;
                    py_next     = by_reg;
                    dist_next   = sq_root;
                    ew_next     = '0;
                    eh_next     = '0;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    bps_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (ssum[63:0]),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            dedup_reg    <= DEDUP_BOTH;
            xscale_reg   <= CFG_W'(256);
            yscale_reg   <= CFG_W'(256);
            ctrl_cnt_reg <= '0;
            ready_reg    <= 1'b0;
            smp_cnt_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            dedup_reg    <= dedup_next;
            xscale_reg   <= xscale_next;
            yscale_reg   <= yscale_next;
            ctrl_cnt_reg <= ctrl_cnt_next;
            ready_reg    <= ready_next;
            smp_cnt_reg  <= smp_cnt_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        full_reg   <= full_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        qpos_reg   <= qpos_next;
        j_reg      <= j_next;
        t_reg      <= t_next;
        tr_reg     <= tr_next;
        m_reg      <= m_next;
        k_reg      <= k_next;
        nn_reg     <= nn_next;
        acc_reg    <= acc_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        i_reg      <= i_next;
        bd_reg     <= bd_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
        bp_reg     <= bp_next;
        w_reg      <= w_next;
        h_reg      <= h_next;
        sa_reg     <= sa_next;
        sb_reg     <= sb_next;
        a2_reg     <= a2_next;
        p1_reg     <= p1_next;
        status_reg <= status_next;
        spos_reg   <= spos_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        dist_reg   <= dist_next;
        ew_reg     <= ew_next;
        eh_reg     <= eh_next;
        prod_reg   <= prod_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_we)
        begin
            ctrl_x_mem[ctrl_widx] <= coord_x;
            ctrl_y_mem[ctrl_widx] <= coord_y;
        end
    end

    // bernstein weights, restarted at one followed by zeros for each sample
    always_ff @(posedge clk)
    begin
        if (bern_clr)
        begin
            for (int n = 0; n < MAX_CONTROL_POINTS; n++)
            begin
                bern_reg[n] <= (n == 0) ? ONE_Q30 : 32'd0;
            end
        end
        else if (bern_we)
        begin
            bern_reg[k_idx] <= bern_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            smp_mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= smp_mem[i_reg[JW-1:0]];
    end

    assign busy            = state_reg != S_IDLE;
    assign done            = done_reg;
    assign status          = status_reg;
    assign sample_position = spos_reg;
    assign point_x         = px_reg;
    assign point_y         = py_reg;
    assign distance        = dist_reg;
    assign extent_width    = ew_reg;
    assign extent_height   = eh_reg;

    `BPS_ASSERT_NEXT(a_accept_busy, start && !busy, busy || done, "accepted word left no trace")
    `BPS_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")
    `BPS_ASSERT_NOW(a_not_built, done && (status == ST_NOT_BUILT), !ready_reg, "not built with a curve present")
    `BPS_ASSERT_NOW(a_ctrl_bound, 1'b1, ctrl_cnt_reg <= KW'(MAX_CONTROL_POINTS), "control count past store depth")

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for bezier_polyline_sampler_top: directed and random command words
// needs bps_pkg and the sampler rtl; predicts every result word and checks it on done
`timescale 1ns / 1ps

module tb_top;
    import bps_pkg::*;

    localparam int STEPS     = 1023;
    localparam int MAX_CTL   = 16;
    localparam int ITEMS     = 580;
    localparam int WDOG_MAX  = 1500000;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  spos;
        logic [15:0] px;
        logic [15:0] py;
        logic [31:0] dist_val;
        logic [15:0] ew;
        logic [15:0] eh;
    } result_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  operation = OP_LOAD;
    logic signed [15:0] coord_x = '0;
    logic signed [15:0] coord_y = '0;
    logic [9:0]  position = '0;
    logic        last_point = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = CFG_DEDUP;
    logic [15:0] cfg_data = '0;
    logic        busy, done;
    logic [1:0]  status;
    logic [9:0]  sample_position;
    logic signed [15:0] point_x, point_y;
    logic [31:0] distance;
    logic [15:0] extent_width, extent_height;

    bezier_polyline_sampler_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .coord_x(coord_x), .coord_y(coord_y),
        .position(position), .last_point(last_point),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .status(status), .sample_position(sample_position),
        .point_x(point_x), .point_y(point_y), .distance(distance),
        .extent_width(extent_width), .extent_height(extent_height)
    );

    always #1 clk = ~clk;

    // predictor state
    logic [1:0]  dedup_sel = DEDUP_BOTH;
    logic [15:0] scale_x = 16'd256;
    logic [15:0] scale_y = 16'd256;
    int          ctl_x [MAX_CTL];
    int          ctl_y [MAX_CTL];
    int          ctl_n = 0;
    int          smp_x [STEPS+1];
    int          smp_y [STEPS+1];
    int          smp_pos [STEPS+1];
    int          smp_n = 0;
    bit          curve_built = 0;

    result_word_t pending_words[$];
    int  words_sent = 0;
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  burst_left = 0;

    function automatic int sat_round_q30(longint v);
        longint q;
        q = (v + (longint'(1) <<< 29)) >>> 30;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return int'(q);
    endfunction

    function automatic void eval_point(int j, output int px, output int py);
        longint b [MAX_CTL];
        longint t, u, acc, sx, sy;
        int n;
        t = ((longint'(j) <<< 30) + STEPS / 2) / STEPS;
        u = (longint'(1) <<< 30) - t;
        n = ctl_n - 1;
        sx = 0;
        sy = 0;
        foreach (b[k]) b[k] = 0;
        b[0] = longint'(1) <<< 30;
        for (int m = 1; m <= n; m++)
            for (int k = m; k >= 0; k--)
            begin
                acc = 0;
                if (k < m) acc += u * b[k];
                if (k >= 1) acc += t * b[k-1];
                b[k] = (acc + (longint'(1) <<< 29)) >>> 30;
            end
        for (int k = 0; k <= n; k++)
        begin
            sx += b[k] * ctl_x[k];
            sy += b[k] * ctl_y[k];
        end
        px = sat_round_q30(sx);
        py = sat_round_q30(sy);
    endfunction

    function automatic void build_curve();
        int ox, oy, cx, cy;
        bit keep;
        eval_point(0, ox, oy);
        smp_x[0] = ox;
        smp_y[0] = oy;
        smp_pos[0] = 0;
        smp_n = 1;
        for (int j = 1; j <= STEPS; j++)
        begin
            eval_point(j, cx, cy);
            keep = (dedup_sel == DEDUP_BOTH && (cx != ox || cy != oy)) ||
                   (dedup_sel == DEDUP_X && cx != ox) ||
                   (dedup_sel == DEDUP_Y && cy != oy);
            if (keep && smp_n < STEPS + 1)
            begin
                smp_x[smp_n] = cx;
                smp_y[smp_n] = cy;
                smp_pos[smp_n] = j;
                smp_n++;
                ox = cx;
                oy = cy;
            end
        end
        // a lone sample is doubled
        if (smp_n == 1)
        begin
            smp_x[1] = smp_x[0];
            smp_y[1] = smp_y[0];
            smp_n = 2;
        end
        smp_pos[smp_n-1] = STEPS;
        curve_built = 1;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic result_word_t curve_predict(op_t op, int qx, int qy, int qpos, bit last);
        result_word_t w;
        int best, w_ext, h_ext;
        longint d, bestd, dx, dy;
        longint unsigned a, b, a2, s, r;
        w = '0;
        best = 0;
        bestd = 0;
        if (op == OP_LOAD)
        begin
            if (ctl_n < MAX_CTL)
            begin
                ctl_x[ctl_n] = qx;
                ctl_y[ctl_n] = qy;
                ctl_n++;
            end
            else
                w.status = ST_FULL;
            if (last && ctl_n > 0)
            begin
                build_curve();
                ctl_n = 0;
            end
            return w;
        end
        if (!curve_built)
        begin
            w.status = ST_NOT_BUILT;
            return w;
        end
        if (op == OP_NEAREST)
        begin
            for (int i = 0; i < smp_n; i++)
            begin
                dx = smp_x[i] - qx;
                dy = smp_y[i] - qy;
                d = dx * dx + dy * dy;
                if (i == 0 || d < bestd)
                begin
                    bestd = d;
                    best = i;
                end
            end
            dx = smp_x[best] - qx;
            dy = smp_y[best] - qy;
            a = longint'(scale_x) * (dx < 0 ? -dx : dx);
            b = longint'(scale_y) * (dy < 0 ? -dy : dy);
            a2 = a * a;
            s = a2 + b * b;
            r = (s < a2) ? 64'hFFFF_FFFF : int_sqrt(s);
            w.dist_val = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
        end
        else if (op == OP_AT_POS)
        begin
            for (int i = 0; i < smp_n; i++)
            begin
                d = smp_pos[i] - qpos;
                if (d < 0) d = -d;
                if (i == 0 || d <= bestd)
                begin
                    bestd = d;
                    best = i;
                end
            end
        end
        else
        begin
            w_ext = 0;
            h_ext = 0;
            for (int i = 0; i < smp_n; i++)
            begin
                if (smp_x[i] >= w_ext) w_ext = smp_x[i] + 1;
                if (smp_y[i] >= h_ext) h_ext = smp_y[i] + 1;
            end
            w.ew = w_ext[15:0];
            w.eh = h_ext[15:0];
            return w;
        end
        w.spos = smp_pos[best][9:0];
        w.px = smp_x[best][15:0];
        w.py = smp_y[best][15:0];
        return w;
    endfunction

    // caller stands at a rising edge; start stays high on return
    task automatic send_word(op_t op, int x, int y, int pos, bit last);
        start <= 1'b1;
        operation <= op;
        coord_x <= x[15:0];
        coord_y <= y[15:0];
        position <= pos[9:0];
        last_point <= last;
        @(negedge clk);
        while (busy) @(negedge clk);
        @(posedge clk);
        pending_words.insert(pending_words.size(), curve_predict(op, x, y, pos, last));
        words_sent++;
        idle_cycles = 0;
    endtask

    // random bursts with random gaps
    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0 || busy) @(posedge clk);
    endtask

    task automatic set_regs(logic [1:0] dm, logic [15:0] xs, logic [15:0] ys);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= CFG_DEDUP;
        cfg_data <= {14'd0, dm};
        @(posedge clk);
        cfg_index <= CFG_XSCALE;
        cfg_data <= xs;
        @(posedge clk);
        cfg_index <= CFG_YSCALE;
        cfg_data <= ys;
        @(posedge clk);
        cfg_write <= 1'b0;
        dedup_sel = dm;
        scale_x = xs;
        scale_y = ys;
        @(posedge clk);
    endtask

    function automatic int rand_coord();
        return int'($signed(16'($urandom)));
    endfunction

    // checker
    always @(negedge clk)
    begin
        result_word_t got, want;
        if (rst_n && done)
        begin
            idle_cycles = 0;
            got = '{status, sample_position, point_x, point_y, distance,
                    extent_width, extent_height};
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: %p", got);
            end
            else
            begin
                want = pending_words.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        idle_cycles++;
        if (idle_cycles > WDOG_MAX)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_queries_before_build();
        send_word(OP_NEAREST, 0, 0, 0, 0);
        send_word(OP_AT_POS, 0, 0, 1023, 0);
        send_word(OP_EXTENTS, 0, 0, 0, 0);
    endtask

    // seventeen loads: the last overflows the store and still builds
    task automatic test_full_store();
        for (int i = 0; i < MAX_CTL + 1; i++)
            send_word(OP_LOAD, (i % 2) ? 32767 : -32768, (i % 3) ? -32768 : 32767,
                      (i % 2) ? 1023 : 0, i == MAX_CTL);
        send_word(OP_NEAREST, 32767, -32768, 0, 0);
        send_word(OP_AT_POS, 0, 0, 0, 0);
        send_word(OP_EXTENTS, 0, 0, 0, 0);
    endtask

    task automatic test_single_sample();
        send_word(OP_LOAD, -5, 7, 0, 1);
        send_word(OP_AT_POS, 0, 0, 1023, 0);
        send_word(OP_NEAREST, -32768, 32767, 512, 0);
    endtask

    task automatic test_random_curves();
        int seq, npts, spread, cx, cy, nq, pick;
        logic [15:0] xs, ys;
        seq = 0;
        while (words_sent < ITEMS)
        begin
            if (seq % 5 == 0)
            begin
                pick = $urandom_range(0, 3);
                xs = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                     (pick == 2) ? 16'd256 : 16'($urandom);
                pick = $urandom_range(0, 3);
                ys = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                     (pick == 2) ? 16'd256 : 16'($urandom);
                set_regs(2'($urandom_range(0, 3)), xs, ys);
                @(posedge clk);
            end
            seq++;
            pick = $urandom_range(0, 19);
            npts = (pick < 6) ? 1 : (pick < 14) ? 2 : (pick < 19) ? 3 : 4;
            // mostly small curves keep the sample store short
            spread = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 40) : 0;
            cx = $urandom_range(0, 64000) - 32000;
            cy = $urandom_range(0, 64000) - 32000;
            for (int i = 0; i < npts; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_word(op_t'($urandom_range(1, 3)), rand_coord(), rand_coord(),
                              $urandom_range(0, 1023), $urandom_range(0, 1));
                    pace();
                end
                if (spread == 0)
                    send_word(OP_LOAD, rand_coord(), rand_coord(),
                              $urandom_range(0, 1023), i == npts - 1);
                else
                    send_word(OP_LOAD, cx + $urandom_range(0, 2 * spread) - spread,
                              cy + $urandom_range(0, 2 * spread) - spread,
                              $urandom_range(0, 1023), i == npts - 1);
                pace();
            end
            nq = $urandom_range(6, 14);
            for (int i = 0; i < nq; i++)
            begin
                if ($urandom_range(0, 1))
                    send_word(op_t'($urandom_range(1, 3)),
                              cx + $urandom_range(0, 100) - 50,
                              cy + $urandom_range(0, 100) - 50,
                              $urandom_range(0, 1023), $urandom_range(0, 1));
                else
                    send_word(op_t'($urandom_range(1, 3)), rand_coord(), rand_coord(),
                              $urandom_range(0, 1023), $urandom_range(0, 1));
                pace();
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_queries_before_build();
        test_full_store();
        test_single_sample();
        set_regs(DEDUP_X, 16'hFFFF, 16'h0000);
        @(posedge clk);
        test_random_curves();
        drain();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/bps_pkg.sv
sv/bps_isqrt.sv
sv/bezier_polyline_sampler_top.sv
bench/tb_top.sv
